// ----- design/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Texture shelf packer package
// Shared types and constants for the shelf packer and its doubling unit.
// ----------------------------------------------------------------------------
package tsp_pkg;

   // Page side limit for the doubling search and cap on the used extent.
   localparam logic [14:0] TSP_PAGE_LIMIT = 15'd8192;
   localparam logic [14:0] TSP_EXTENT_CAP = 15'd16384;
   // Highest page index; later pages reuse it.
   localparam logic [11:0] TSP_MAX_PAGE   = 12'd4095;
   localparam logic [13:0] TSP_BASE_RESET = 14'd2048;

   typedef struct packed {
      logic [13:0] image_width;
      logic [13:0] image_height;
      logic [5:0]  border_size;
      logic [7:0]  group_id;
      logic        separate_flag;
   } tsp_req_type;

   typedef struct packed {
      logic [11:0] page_number;
      logic [13:0] pos_x;
      logic [13:0] pos_y;
      logic        opened_page;
      logic [14:0] used_width;
      logic [14:0] used_height;
      logic        too_large;
   } tsp_rsp_type;

   // Control of the shared doubling unit.
   typedef struct packed {
      logic        load;
      logic [14:0] load_value;
      logic        step;
      logic [15:0] target;
      logic [14:0] cap;
   } tsp_dbl_ctl_type;

   typedef enum logic [2:0] {
      TSP_IDLE,
      TSP_SIZE,
      TSP_PLACE,
      TSP_EXT_W,
      TSP_EXT_H,
      TSP_FINISH
   } tsp_state_type;

endpackage

// ----- design/tsp_dbl_unit.sv -----
// ----------------------------------------------------------------------------
// Texture shelf packer doubling unit
// Holds a loaded candidate and doubles it one step per cycle while step is
// asserted and load is not; done shows once it no longer stays below both the target and the cap.
// ----------------------------------------------------------------------------
module tsp_dbl_unit (
   input  logic                     clock,
   input  tsp_pkg::tsp_dbl_ctl_type ctl,
   output logic [14:0]              value,
   output logic                     done
);
   import tsp_pkg::*;

   logic [14:0] value_ff;
   logic [14:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = ctl.load_value;
      end else if (ctl.step) begin
         value_in = {value_ff[13:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   // The search ends once the candidate reaches the target or the cap.
   assign done  = !(({1'b0, value_ff} < ctl.target) && (value_ff < ctl.cap));

endmodule

// ----- design/texture_shelf_packer.sv -----
// ----------------------------------------------------------------------------
// Texture shelf packer
// Places sorted, border-padded texture rectangles on square atlas pages by
// shelf packing and reports page, position and used power-of-two extent.
// ----------------------------------------------------------------------------
// Flow: page size search, placement, used width search, used height search,
// then the registered response; the page side doubles from the base size while
// below 8192, the used extent up to 16384. A too large texture skips from the
// size search to the response. The one shared doubling unit serves all searches,
// so a new request is taken only in idle, once the last response is registered.
// Reset: synchronous, active high; all pages closed, base size 2048.
// ----------------------------------------------------------------------------
module texture_shelf_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tsp_pkg::tsp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tsp_pkg::tsp_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [13:0]          csr_data
);
   import tsp_pkg::*;

   // Control state.
   tsp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Configuration register.
   logic [13:0]   base_ff, base_in;

   // Packing state.
   logic          page_open_ff, page_open_in;
   logic          any_page_ff, any_page_in;
   logic [11:0]   page_counter_ff, page_counter_in;
   logic [7:0]    open_group_ff, open_group_in;
   logic [14:0]   open_size_ff, open_size_in;
   logic [14:0]   cursor_x_ff, cursor_x_in;
   logic [14:0]   cursor_y_ff, cursor_y_in;
   logic [14:0]   shelf_ff, shelf_in;
   logic [14:0]   extent_w_ff, extent_w_in;
   logic [14:0]   extent_h_ff, extent_h_in;

   // Captured transaction and per-item working values.
   logic [15:0]   w_ff, w_in;
   logic [15:0]   h_ff, h_in;
   logic [5:0]    border_ff, border_in;
   logic [7:0]    group_ff, group_in;
   logic          sep_ff, sep_in;
   logic [14:0]   size_ff, size_in;
   logic          too_large_ff, too_large_in;
   logic          opened_ff, opened_in;
   logic [13:0]   pos_x_ff, pos_x_in;
   logic [13:0]   pos_y_ff, pos_y_in;
   logic [15:0]   sum_w_ff, sum_w_in;
   logic [15:0]   sum_h_ff, sum_h_in;
   tsp_rsp_type   rsp_data_ff, rsp_data_in;

   // Shared doubling unit.
   tsp_dbl_ctl_type dbl_ctl;
   logic [14:0]     dbl_value;
   logic            dbl_done;

   // Placement decode.
   logic [15:0] need;
   logic [15:0] wrap_x_sum;
   logic        fresh_base;
   logic        wrap;
   logic [15:0] cx1, cy1;
   logic [14:0] sh1;
   logic [15:0] fit_y_sum;
   logic        fresh;
   logic        rsp_free;
   logic        req_accept;

   tsp_dbl_unit u_dbl (
      .clock (clock),
      .ctl   (dbl_ctl),
      .value (dbl_value),
      .done  (dbl_done)
   );

   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign need       = (w_ff > h_ff) ? w_ff : h_ff;

   // A page is reused only when it is open for the same group and page size
   // and the item is not separate. A shelf wraps when the item runs past the
   // right edge; the page closes when the item then runs past the bottom.
   always_comb begin
      fresh_base = sep_ff || !page_open_ff || (open_group_ff != group_ff) ||
                   (size_ff != open_size_ff);
      wrap_x_sum = {1'b0, cursor_x_ff} + w_ff;
      wrap       = !fresh_base && (wrap_x_sum > {1'b0, size_ff});
      cx1        = wrap ? 16'd0 : {1'b0, cursor_x_ff};
      cy1        = wrap ? ({1'b0, cursor_y_ff} + {1'b0, shelf_ff}) : {1'b0, cursor_y_ff};
      sh1        = wrap ? 15'd0 : shelf_ff;
      fit_y_sum  = cy1 + h_ff;
      fresh      = fresh_base || (fit_y_sum > {1'b0, size_ff});
      if (fresh) begin
         cx1 = 16'd0;
         cy1 = 16'd0;
         sh1 = 15'd0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TSP_IDLE: begin
            if (req_accept) begin
               state_in = TSP_SIZE;
            end
         end
         TSP_SIZE: begin
            if (dbl_done) begin
               state_in = ({1'b0, dbl_value} < need) ? TSP_FINISH : TSP_PLACE;
            end
         end
         TSP_PLACE: begin
            state_in = TSP_EXT_W;
         end
         TSP_EXT_W: begin
            if (dbl_done) begin
               state_in = TSP_EXT_H;
            end
         end
         TSP_EXT_H: begin
            if (dbl_done) begin
               state_in = TSP_FINISH;
            end
         end
         TSP_FINISH: begin
            if (rsp_free) begin
               state_in = TSP_IDLE;
            end
         end
         default: begin
            state_in = TSP_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake and control of the doubling unit.
   always_comb begin
      req_ready          = 1'b0;
      dbl_ctl.load       = 1'b0;
      dbl_ctl.load_value = 15'd1;
      dbl_ctl.step       = 1'b0;
      dbl_ctl.target     = need;
      dbl_ctl.cap        = TSP_PAGE_LIMIT;
      unique case (state_ff)
         TSP_IDLE: begin
            req_ready          = 1'b1;
            dbl_ctl.load       = 1'b1;
            // A base size of zero acts as one.
            dbl_ctl.load_value = (base_ff == 14'd0) ? 15'd1 : {1'b0, base_ff};
         end
         TSP_SIZE: begin
            dbl_ctl.step = !dbl_done;
         end
         TSP_PLACE: begin
            // The used extent only grows, so the search starts from it.
            dbl_ctl.load       = 1'b1;
            dbl_ctl.load_value = fresh ? 15'd1 : extent_w_ff;
         end
         TSP_EXT_W: begin
            dbl_ctl.target     = sum_w_ff;
            dbl_ctl.cap        = TSP_EXTENT_CAP;
            dbl_ctl.load       = dbl_done;
            dbl_ctl.load_value = extent_h_ff;
            dbl_ctl.step       = !dbl_done;
         end
         TSP_EXT_H: begin
            dbl_ctl.target = sum_h_ff;
            dbl_ctl.cap    = TSP_EXTENT_CAP;
            dbl_ctl.step   = !dbl_done;
         end
         TSP_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      base_in         = base_ff;
      page_open_in    = page_open_ff;
      any_page_in     = any_page_ff;
      page_counter_in = page_counter_ff;
      open_group_in   = open_group_ff;
      open_size_in    = open_size_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      shelf_in        = shelf_ff;
      extent_w_in     = extent_w_ff;
      extent_h_in     = extent_h_ff;
      w_in            = w_ff;
      h_in            = h_ff;
      border_in       = border_ff;
      group_in        = group_ff;
      sep_in          = sep_ff;
      size_in         = size_ff;
      too_large_in    = too_large_ff;
      opened_in       = opened_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      sum_w_in        = sum_w_ff;
      sum_h_in        = sum_h_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         base_in = csr_data;
      end

      if (req_accept) begin
         w_in      = {2'b00, req_data.image_width} + {9'd0, req_data.border_size, 1'b0};
         h_in      = {2'b00, req_data.image_height} + {9'd0, req_data.border_size, 1'b0};
         border_in = req_data.border_size;
         group_in  = req_data.group_id;
         sep_in    = req_data.separate_flag;
      end

      if ((state_ff == TSP_SIZE) && dbl_done) begin
         size_in      = dbl_value;
         too_large_in = {1'b0, dbl_value} < need;
      end

      if (state_ff == TSP_PLACE) begin
         opened_in = fresh;
         if (fresh) begin
            if (!any_page_ff) begin
               any_page_in     = 1'b1;
               page_counter_in = 12'd0;
            end else if (page_counter_ff != TSP_MAX_PAGE) begin
               page_counter_in = page_counter_ff + 12'd1;
            end
            extent_w_in = 15'd1;
            extent_h_in = 15'd1;
         end
         pos_x_in     = cx1[13:0] + {8'd0, border_ff};
         pos_y_in     = cy1[13:0] + {8'd0, border_ff};
         sum_w_in     = cx1 + w_ff;
         sum_h_in     = cy1 + h_ff;
         cursor_x_in  = sum_w_in[14:0];
         cursor_y_in  = cy1[14:0];
         shelf_in     = (h_ff > {1'b0, sh1}) ? h_ff[14:0] : sh1;
         open_size_in = size_ff;
         if (sep_ff) begin
            page_open_in  = 1'b0;
            open_group_in = 8'd0;
         end else begin
            page_open_in  = 1'b1;
            open_group_in = group_ff;
         end
      end

      if ((state_ff == TSP_EXT_W) && dbl_done) begin
         extent_w_in = dbl_value;
      end
      if ((state_ff == TSP_EXT_H) && dbl_done) begin
         extent_h_in = dbl_value;
      end

      if ((state_ff == TSP_FINISH) && rsp_free) begin
         rsp_valid_in = 1'b1;
         if (too_large_ff) begin
            rsp_data_in.page_number = 12'd0;
            rsp_data_in.pos_x       = 14'd0;
            rsp_data_in.pos_y       = 14'd0;
            rsp_data_in.opened_page = 1'b0;
            rsp_data_in.used_width  = 15'd1;
            rsp_data_in.used_height = 15'd1;
            rsp_data_in.too_large   = 1'b1;
         end else begin
            rsp_data_in.page_number = page_counter_ff;
            rsp_data_in.pos_x       = pos_x_ff;
            rsp_data_in.pos_y       = pos_y_ff;
            rsp_data_in.opened_page = opened_ff;
            rsp_data_in.used_width  = extent_w_ff;
            rsp_data_in.used_height = extent_h_ff;
            rsp_data_in.too_large   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= TSP_IDLE;
         rsp_valid_ff    <= 1'b0;
         base_ff         <= TSP_BASE_RESET;
         page_open_ff    <= 1'b0;
         any_page_ff     <= 1'b0;
         page_counter_ff <= 12'd0;
         open_group_ff   <= 8'd0;
         open_size_ff    <= 15'd0;
         cursor_x_ff     <= 15'd0;
         cursor_y_ff     <= 15'd0;
         shelf_ff        <= 15'd0;
         extent_w_ff     <= 15'd1;
         extent_h_ff     <= 15'd1;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         base_ff         <= base_in;
         page_open_ff    <= page_open_in;
         any_page_ff     <= any_page_in;
         page_counter_ff <= page_counter_in;
         open_group_ff   <= open_group_in;
         open_size_ff    <= open_size_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         shelf_ff        <= shelf_in;
         extent_w_ff     <= extent_w_in;
         extent_h_ff     <= extent_h_in;
      end
   end

   // Item registers carry no reset.
   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      h_ff         <= h_in;
      border_ff    <= border_in;
      group_ff     <= group_in;
      sep_ff       <= sep_in;
      size_ff      <= size_in;
      too_large_ff <= too_large_in;
      opened_ff    <= opened_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      sum_w_ff     <= sum_w_in;
      sum_h_ff     <= sum_h_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted transaction always starts the page size search.
   a_accept_starts_size: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == TSP_SIZE))
      else $error("accepted transaction did not start the size search");

   // The cursor never runs past the right or bottom edge of an open page.
   a_cursor_in_page: assert property (@(posedge clock) disable iff (reset)
      page_open_ff |-> (cursor_x_ff <= open_size_ff) && (cursor_y_ff <= open_size_ff))
      else $error("cursor outside the open page");

   // The extent search walks powers of two only.
   a_extent_pow2: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == TSP_EXT_W) || (state_ff == TSP_EXT_H)) |->
      $onehot(dbl_value) && $onehot(extent_w_ff) && $onehot(extent_h_ff))
      else $error("used extent is not a power of two");

   // A rejected texture reports no placement.
   a_too_large_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.too_large) |->
      (rsp_data.opened_page == 1'b0) && (rsp_data.page_number == 12'd0) &&
      (rsp_data.used_width == 15'd1) && (rsp_data.used_height == 15'd1))
      else $error("too large response carries a placement");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Texture shelf packer testbench
// Drives sorted texture rectangles into the shelf packer. A local placement
// predictor follows every accepted request, and each response is compared
// field by field with the oldest predicted placement. Both channels idle and
// stall at random. The base page size is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import tsp_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   // Settling time after every texture is answered.
   localparam int DRAIN_CYCLES = 64;
   // Cycles without any transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tsp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tsp_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [13:0] csr_data = '0;

   texture_shelf_packer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Textures waiting to be driven, and placements waiting for their response.
   tsp_req_type pending_textures[$];
   tsp_rsp_type expected_placements[$];
   int unsigned mismatch_count = 0;

   // Handshakes seen at the last rising edge, read by the drivers at the
   // following falling edge.
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   // --------------------------------------------------------------------------
   // Placement predictor state. These mirror the packer's page bookkeeping:
   // the open page, its group and side, the shelf cursor and the used extent.
   // --------------------------------------------------------------------------
   bit [13:0] base_side;
   bit        shelf_page_open;
   bit        any_page_seen;
   bit [11:0] page_index;
   bit [7:0]  shelf_group;
   bit [14:0] page_side;
   bit [14:0] cursor_x;
   bit [14:0] cursor_y;
   bit [14:0] shelf_depth;
   bit [14:0] extent_x;
   bit [14:0] extent_y;

   // Smallest power of two not below the value, capped at the extent limit.
   function automatic int unsigned extent_pow2(input int unsigned v);
      int unsigned p;
      p = 1;
      while (p < v && p < TSP_EXTENT_CAP)
         p = p << 1;
      return p;
   endfunction

   // Works out where one texture lands and advances the page state with it.
   function automatic tsp_rsp_type predict_placement(input tsp_req_type t);
      int unsigned pad_w;
      int unsigned pad_h;
      int unsigned need;
      int unsigned side;
      int unsigned ext;
      bit          fresh;
      tsp_rsp_type r;
      pad_w = t.image_width + 2 * t.border_size;
      pad_h = t.image_height + 2 * t.border_size;
      need = (pad_w > pad_h) ? pad_w : pad_h;
      // A base of zero behaves as one; the side doubles up to the page limit.
      side = (base_side == 0) ? 1 : base_side;
      while (side < need && side < TSP_PAGE_LIMIT)
         side = side << 1;
      r = '0;
      if (side < need) begin
         // Too large: nothing is placed and the page state stays as it was.
         r.used_width = 1;
         r.used_height = 1;
         r.too_large = 1'b1;
         return r;
      end
      fresh = t.separate_flag || !shelf_page_open || shelf_group != t.group_id
              || side != page_side;
      // Step down to a new shelf when the row is full.
      if (!fresh && cursor_x + pad_w > side) begin
         cursor_x = 0;
         cursor_y = cursor_y + shelf_depth;
         shelf_depth = 0;
      end
      if (!fresh && cursor_y + pad_h > side)
         fresh = 1'b1;
      if (fresh) begin
         // The page index saturates; later pages reuse the last one.
         if (!any_page_seen) begin
            any_page_seen = 1'b1;
            page_index = 0;
         end else if (page_index < TSP_MAX_PAGE) begin
            page_index = page_index + 12'd1;
         end
         shelf_page_open = 1'b1;
         shelf_group = t.group_id;
         page_side = 15'(side);
         cursor_x = 0;
         cursor_y = 0;
         shelf_depth = 0;
         extent_x = 1;
         extent_y = 1;
      end
      ext = extent_pow2(cursor_x + pad_w);
      if (ext > extent_x)
         extent_x = 15'(ext);
      ext = extent_pow2(cursor_y + pad_h);
      if (ext > extent_y)
         extent_y = 15'(ext);
      r.page_number = page_index;
      r.pos_x = 14'(cursor_x + t.border_size);
      r.pos_y = 14'(cursor_y + t.border_size);
      r.opened_page = fresh;
      r.used_width = extent_x;
      r.used_height = extent_y;
      cursor_x = 15'(cursor_x + pad_w);
      if (pad_h > shelf_depth)
         shelf_depth = 15'(pad_h);
      // A separate texture closes its page behind it.
      if (t.separate_flag) begin
         shelf_page_open = 1'b0;
         shelf_group = 0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // --------------------------------------------------------------------------
   // Monitor. Responses are checked first so that a request and a response
   // in the same cycle never see each other's effect. The predictor runs on
   // each accepted request, and a configuration transaction updates its copy
   // of the base size.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      tsp_rsp_type want;
      if (reset) begin
         base_side = TSP_BASE_RESET;
         shelf_page_open = 1'b0;
         any_page_seen = 1'b0;
         page_index = 0;
         shelf_group = 0;
         page_side = 0;
         cursor_x = 0;
         cursor_y = 0;
         shelf_depth = 0;
         extent_x = 1;
         extent_y = 1;
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_placements.size() == 0) begin
               $display("%0t: response expected none, actual page %0d at %0d,%0d",
                        $time, rsp_data.page_number, rsp_data.pos_x, rsp_data.pos_y);
               mismatch_count++;
            end else begin
               want = expected_placements.pop_front();
               check_field("page_number", want.page_number, rsp_data.page_number);
               check_field("pos_x", want.pos_x, rsp_data.pos_x);
               check_field("pos_y", want.pos_y, rsp_data.pos_y);
               check_field("opened_page", want.opened_page, rsp_data.opened_page);
               check_field("used_width", want.used_width, rsp_data.used_width);
               check_field("used_height", want.used_height, rsp_data.used_height);
               check_field("too_large", want.too_large, rsp_data.too_large);
            end
         end
         if (req_valid && req_ready)
            expected_placements.push_back(predict_placement(req_data));
         if (csr_valid && csr_ready)
            base_side = csr_data;
         req_fired <= req_valid && req_ready;
         rsp_fired <= rsp_valid && rsp_ready;
      end
   end

   // --------------------------------------------------------------------------
   // Request driver. A free slot either waits out the drawn gap or presents
   // the next pending texture. With a zero gap valid simply stays high into
   // the next transaction. Calm stretches switch the gaps off for a while.
   // --------------------------------------------------------------------------
   int unsigned req_gap = 0;
   bit          req_calm = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || req_fired) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_textures.size() != 0) begin
            req_data <= pending_textures.pop_front();
            req_valid <= 1'b1;
            req_gap <= req_calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 31) == 0)
               req_calm <= !req_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Response stall. After each accepted response the receiver may hold
   // ready low for a random stall; otherwise ready stays high.
   // --------------------------------------------------------------------------
   int unsigned rsp_stall = 0;
   bit          rsp_calm = 1'b0;

   always @(negedge clock) begin : rsp_driver
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_fired) begin
         stall = rsp_calm ? 0 : $urandom_range(0, 6);
         if ($urandom_range(0, 31) == 0)
            rsp_calm <= !rsp_calm;
         if (stall == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_stall <= stall - 1;
         end
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: a long run of cycles with no transaction at all means a hang.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers.
   // --------------------------------------------------------------------------
   function automatic tsp_req_type texture(input int unsigned w, input int unsigned h,
                                           input int unsigned b, input int unsigned g,
                                           input bit s);
      tsp_req_type t;
      t.image_width = 14'(w);
      t.image_height = 14'(h);
      t.border_size = 6'(b);
      t.group_id = 8'(g);
      t.separate_flag = s;
      return t;
   endfunction

   // Waits until every texture is accepted and answered, then lets the block
   // settle before the register may change.
   task automatic drain();
      while (pending_textures.size() != 0 || req_valid
             || expected_placements.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [13:0] value);
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Runs of textures sharing a group, with heights sorted downward inside a
   // run so that shelves fill the way a real atlas build fills them. A share
   // of larger, oversize, zero-sized and separate textures is mixed in.
   task automatic queue_shelf_runs(input int unsigned count);
      int unsigned run_left;
      int unsigned shelf_top;
      int unsigned pick;
      int unsigned w;
      int unsigned h;
      int unsigned b;
      bit [7:0]    grp;
      run_left = 0;
      shelf_top = 1;
      grp = 0;
      repeat (count) begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
               grp = 8'($urandom);
            shelf_top = $urandom_range(1, 256);
         end
         run_left--;
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            w = $urandom_range(1, 256);
            h = $urandom_range(1, shelf_top);
            shelf_top = h;
         end else if (pick < 90) begin
            w = $urandom_range(1, 8192);
            h = $urandom_range(1, 8192);
         end else if (pick < 97) begin
            w = $urandom_range(0, 16383);
            h = $urandom_range(0, 16383);
         end else begin
            w = 0;
            h = $urandom_range(0, 3);
         end
         b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
         pending_textures.push_back(texture(w, h, b, grp, $urandom_range(0, 19) == 0));
      end
   endtask

   // --------------------------------------------------------------------------
   // Test sequence. Each phase runs with one base page size; the register is
   // only rewritten once the block has gone quiet.
   // --------------------------------------------------------------------------
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed textures at the reset base size of 2048.
      pending_textures.push_back(texture(1, 1, 0, 0, 0));          // first page ever
      pending_textures.push_back(texture(100, 50, 2, 0, 0));       // same shelf
      pending_textures.push_back(texture(2000, 40, 0, 0, 0));      // row full, new shelf
      pending_textures.push_back(texture(30, 2000, 0, 0, 0));      // no room below
      pending_textures.push_back(texture(10, 10, 0, 7, 0));        // group change
      pending_textures.push_back(texture(10, 10, 0, 7, 1));        // separate texture
      pending_textures.push_back(texture(10, 10, 0, 7, 0));        // page was closed
      pending_textures.push_back(texture(3000, 20, 0, 7, 0));      // doubles to 4096
      pending_textures.push_back(texture(8192, 8192, 0, 7, 0));    // exactly the limit
      pending_textures.push_back(texture(8192, 1, 1, 7, 0));       // limit plus border
      pending_textures.push_back(texture(16383, 16383, 63, 255, 1)); // all bits high
      pending_textures.push_back(texture(1, 8192, 32, 255, 0));    // tall oversize
      pending_textures.push_back(texture(0, 0, 0, 255, 0));        // empty texture
      pending_textures.push_back(texture(20, 20, 63, 255, 0));     // widest border
      pending_textures.push_back(texture(5, 5, 0, 255, 0));
      queue_shelf_runs(200);
      drain();

      // Smallest base: nearly every texture sets its own page size.
      write_base(14'd1);
      queue_shelf_runs(150);
      drain();

      write_base(14'd8192);
      queue_shelf_runs(100);
      drain();

      // A base of zero acts as one.
      write_base(14'd0);
      queue_shelf_runs(100);
      drain();

      // Base above the page limit: no doubling, and extents reach their cap.
      write_base(14'd16383);
      pending_textures.push_back(texture(9000, 9000, 0, 3, 0));
      pending_textures.push_back(texture(7000, 100, 0, 3, 0));
      pending_textures.push_back(texture(16383, 1, 0, 4, 0));
      pending_textures.push_back(texture(16383, 1, 1, 4, 0));
      queue_shelf_runs(100);
      drain();

      write_base(14'($urandom_range(1, 8192)));
      queue_shelf_runs(150);
      drain();

      // Back at the reset base size for a closing mix.
      write_base(TSP_BASE_RESET);
      queue_shelf_runs(100);
      drain();

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
